@@ sv/rgba_channel_blend_alu_macros.svh @@
// Assertion macros used by the blend ALU top level
`ifndef RGBA_CHANNEL_BLEND_ALU_MACROS_SVH
`define RGBA_CHANNEL_BLEND_ALU_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define RCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define RCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/rcb_pkg.sv @@
// Package with types and constants of the blend ALU
`timescale 1ns / 1ps
package rcb_pkg;
  localparam int unsigned CH_W = 8;
  localparam int unsigned MAX_CH = 4;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_SCALE = 3'd4,
    OP_INV = 3'd5
  } op_t;

  typedef logic [CH_W-1:0] chan_t;

  // Divider state record; the cells pass remainder and quotient as separate ports
  typedef struct packed {
    logic [15:0] rem;   // partial remainder of x*255
    logic [7:0]  quo;   // quotient bits so far
  } div_t;
endpackage

@@ sv/rcb_cell.sv @@
// One stage of a per-channel pipeline; one stage does one divide bit
`timescale 1ns / 1ps
module rcb_cell (
  input  logic clk,
  input  logic en,
  input  logic [3:0] bit_idx,   // quotient bit handled by this stage
  input  logic [15:0] rem_in,
  input  logic [8:0] quo_in,
  input  logic [7:0] y_in,
  output logic [15:0] rem_out,
  output logic [8:0] quo_out,
  output logic [7:0] y_out
);
  logic [23:0] trial;
  logic [15:0] rem_next;
  logic fits;

  // Compare remainder against y shifted to this stage's bit position
  always_comb begin
    trial = {16'd0, y_in} << bit_idx;
    fits = ({8'd0, rem_in} >= trial) && (y_in != 8'd0);
    rem_next = fits ? rem_in - trial[15:0] : rem_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      quo_out <= quo_in | (fits ? (9'd1 << bit_idx) : 9'd0);
      y_out <= y_in;
    end
  end
endmodule

@@ sv/rcb_lane.sv @@
// One channel lane: operand stage, a row of divide cells, result select
`timescale 1ns / 1ps
module rcb_lane (
  input  logic clk,
  input  logic en,
  input  logic [2:0] op,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic signed [15:0] s,
  output logic [7:0] res
);
  import rcb_pkg::*;
  localparam int unsigned NCELL = 9;

  // Stage 0: add, sub and invert results and the multiply and scale products, registered
  logic [8:0] sum;
  logic [15:0] prod;
  logic signed [24:0] sprod;
  logic [7:0] res0;
  logic [2:0] op0;
  logic [15:0] mprod;
  logic signed [24:0] sp;
  logic [7:0] fast;

  always_comb begin
    sum = {1'b0, x} + {1'b0, y};
    prod = x * y;
    sprod = $signed({17'd0, x}) * s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= op;
      mprod <= prod;
      sp <= sprod;
      case (op)
        OP_ADD: res0 <= sum[8] ? CH_MAX : sum[7:0];
        OP_SUB: res0 <= (x > y) ? x - y : 8'd0;
        OP_INV: res0 <= CH_MAX - y;
        default: res0 <= 8'd0;
      endcase
    end
  end

  // Divide by 255: q = (p + (p>>8) + 1) >> 8 exact for p <= 65025
  logic [16:0] mq;
  always_comb begin
    mq = {1'b0, mprod} + {9'd0, mprod[15:8]} + 17'd1;
    case (op0)
      OP_MUL: fast = mq[15:8];
      OP_SCALE: fast = (sp <= 0) ? 8'd0 : ((|sp[23:16]) ? CH_MAX : sp[15:8]);
      default: fast = res0;
    endcase
  end

  // Divide chain: quotient bits 8 down to 0 of x*255/y
  logic [15:0] rem [NCELL+1];
  logic [8:0] quo [NCELL+1];
  logic [7:0] yv [NCELL+1];
  logic [7:0] fres [NCELL+1];
  logic [2:0] fop [NCELL+1];

  assign rem[0] = ({8'd0, x} << 8) - {8'd0, x};
  assign quo[0] = 9'd0;
  assign yv[0] = y;
  assign fres[1] = fast;
  assign fop[1] = op0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rcb_cell u_cell (
      .clk(clk), .en(en), .bit_idx(4'(NCELL - 1 - i)),
      .rem_in(rem[i]), .quo_in(quo[i]), .y_in(yv[i]),
      .rem_out(rem[i+1]), .quo_out(quo[i+1]), .y_out(yv[i+1])
    );
    if (i >= 1) begin : g_side
      always_ff @(posedge clk) begin
        if (en) begin
          fres[i+1] <= fres[i];
          fop[i+1] <= fop[i];
        end
      end
    end
  end

  logic [7:0] dres;
  always_comb begin
    if (yv[NCELL] == 8'd0 || quo[NCELL][8]) dres = CH_MAX;
    else dres = quo[NCELL][7:0];
    res = (fop[NCELL] == OP_DIV) ? dres : fres[NCELL];
  end
endmodule

@@ sv/rgba_channel_blend_alu.sv @@
// Top level of the RGBA8 per-channel blend ALU
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one word per pixel pair: op, both pixels and the Q8.8
//   scale factor. m_axis returns one word per accepted input: the result
//   pixel. Each channel runs in its own lane; ops are add/sub saturating,
//   multiply /255, divide x*255/y, scale by factor, invert second pixel.
//   Throughput: one word per clock while the receiver does not stall. The
//   divide is a row of nine cells, one quotient bit per cell; every word
//   passes the lane pipeline and then one output register before it
//   raises m_axis_tvalid.
//   The pipeline advances whenever its last stage is empty or taken; when
//   the receiver stalls, the whole row holds and s_axis_tready drops.
//   Reset (rst, synchronous) clears all valid bits; payload is not reset.
//   Channels at or above CHANNEL_COUNT pass the first pixel through.
module rgba_channel_blend_alu #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // op[2:0], first r,g,b,a [10:3..], second r,g,b,a, scale_factor[82:67], pad
  input  logic [87:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0] m_axis_tdata
);
  import rcb_pkg::*;
  `include "rgba_channel_blend_alu_macros.svh"
  localparam int unsigned DEPTH = 10;

  logic [DEPTH-1:0] vld;
  logic en;
  logic out_stall;
  logic [7:0] lres [MAX_CH];
  logic [7:0] xpass [MAX_CH][DEPTH];

  // advance when the output stage is free or being taken
  assign en = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[DEPTH-1];
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    if (c < CHANNEL_COUNT) begin : g_lane
      logic [7:0] r9;
      rcb_lane u_lane (
        .clk(clk), .en(en), .op(s_axis_tdata[2:0]),
        .x(s_axis_tdata[3+8*c +: 8]), .y(s_axis_tdata[35+8*c +: 8]),
        .s($signed(s_axis_tdata[82:67])), .res(r9)
      );
      always_ff @(posedge clk) begin
        if (en) lres[c] <= r9;
      end
      assign xpass[c][0] = 8'd0;
    end else begin : g_pass
      assign xpass[c][0] = s_axis_tdata[3+8*c +: 8];
      for (genvar d = 1; d < DEPTH; d++) begin : g_d
        always_ff @(posedge clk) begin
          if (en) xpass[c][d] <= xpass[c][d-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) lres[c] <= xpass[c][DEPTH-1];
      end
    end
    assign m_axis_tdata[8*c +: 8] = lres[c];
  end

  `RCB_ASSERT_IMP(a_stall_hold, clk, rst, out_stall, !s_axis_tready, "input taken in stall")
  `RCB_ASSERT_NEXT(a_out_stay, clk, rst, out_stall, m_axis_tvalid, "output word dropped")
  `RCB_ASSERT_NEXT(a_data_stay, clk, rst, out_stall, $stable(m_axis_tdata), "output changed")
endmodule

@@ dv/rgba_blend_checker.sv @@
// Checker for the blend ALU: predicts each result pixel and compares it
`timescale 1ns / 1ps
module rgba_blend_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [87:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_data,
  output int          fail_count,
  output int          pending,
  output int          matched
);
  import rcb_pkg::*;

  logic [31:0] pixel_queue[$];

  function automatic chan_t blend_channel(logic [2:0] opc, chan_t x, chan_t y,
                                          logic signed [15:0] s);
    int unsigned r;
    int p;
    case (opc)
      OP_ADD: begin
        r = x + y;
        return (r > 255) ? CH_MAX : chan_t'(r);
      end
      OP_SUB: return (x > y) ? chan_t'(x - y) : 8'd0;
      OP_MUL: return chan_t'((int'(x) * int'(y)) / 255);
      OP_DIV: begin
        if (y == 0) return CH_MAX;
        r = (int'(x) * 255) / int'(y);
        return (r > 255) ? CH_MAX : chan_t'(r);
      end
      OP_SCALE: begin
        p = int'(x) * int'(s);
        if (p <= 0) return 8'd0;
        r = p >>> 8;
        return (r > 255) ? CH_MAX : chan_t'(r);
      end
      OP_INV: return CH_MAX - y;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [31:0] blend_pixel(logic [87:0] d);
    logic [31:0] res;
    for (int ch = 0; ch < 4; ch++)
      res[8*ch +: 8] = blend_channel(d[2:0], d[3+8*ch +: 8], d[35+8*ch +: 8], d[82:67]);
    return res;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      matched <= 0;
      pixel_queue.delete();
    end else begin
      if (in_valid && in_ready) pixel_queue.push_back(blend_pixel(in_data));
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          errs = 1;
        end else begin
          want = pixel_queue.pop_front();
          for (int ch = 0; ch < 4; ch++)
            if (want[8*ch +: 8] !== out_data[8*ch +: 8]) begin
              $display("%0t: channel %0d expected %h actual %h", $time, ch,
                       want[8*ch +: 8], out_data[8*ch +: 8]);
              errs++;
            end
          matched <= matched + 1;
        end
      end
      fail_count <= fail_count + errs;
    end
    pending = pixel_queue.size();
  end
endmodule

@@ dv/testbench.sv @@
// Stimulus and verdict for the blend ALU
`timescale 1ns / 1ps
module testbench;
  import rcb_pkg::*;

  localparam int RANDOM_WORDS = 950;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;  // op, first rgba, second rgba, scale, pad
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // out red, green, blue, alpha
  int fail_count, pending, matched;
  int sent = 0;
  int idle_cycles = 0;
  bit no_idle = 0;      // stretch with every cycle busy on both sides
  bit hold_off = 0;     // receiver long stall request
  bit done = 0;
  logic [15:0] dir_scale [4] = '{16'h0100, 16'h7FFF, 16'h8000, 16'h0000};

  always #5 clk = ~clk;

  rgba_channel_blend_alu uut (.*);

  rgba_blend_checker chk (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .fail_count, .pending, .matched
  );

  function automatic logic [87:0] pack_word(logic [2:0] opc, logic [31:0] a, logic [31:0] b,
                                            logic [15:0] s);
    return {5'd0, s, b, a, opc};
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [87:0] random_word();
    logic [31:0] a, b;
    logic [15:0] s;
    for (int ch = 0; ch < 4; ch++) begin
      a[8*ch +: 8] = pick_chan();
      b[8*ch +: 8] = pick_chan();
    end
    case ($urandom_range(0, 3))
      0: s = 16'($urandom_range(0, 1024));
      1: s = 16'h8000 | 16'($urandom);
      default: s = 16'($urandom);
    endcase
    return pack_word(3'($urandom_range(0, 7)), a, b, s);
  endfunction

  // Offer one word, idling at random before it, and hold until accepted
  task automatic send_word(logic [87:0] d);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Receiver: random backpressure, long hold when asked
  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 0;
    else m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 37);
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("rgba_channel_blend_alu: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every op code (unused ones too) at the channel extremes
    for (int o = 0; o < 8; o++) begin
      send_word(pack_word(3'(o), 32'hFF00_FF00, 32'h00FF_FF00, dir_scale[o % 4]));
      send_word(pack_word(3'(o), 32'h80FF_01FF, 32'h0200_FFFF, dir_scale[(o + 1) % 4]));
    end
    send_word(pack_word(OP_DIV, 32'h0A0A_0A0A, 32'h0000_0000, 16'h0));   // divide by zero
    send_word(pack_word(OP_SCALE, 32'hFFFF_FFFF, 32'h0, 16'hFF00));      // negative scale
    send_word(pack_word(OP_SCALE, 32'h01FF_80FF, 32'h0, 16'h0180));

    // Pause the sender until every result has come back
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Long receiver hold while the sender keeps offering words
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 30; i++) send_word(random_word());
    join

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= 300 && i < 450);
      send_word(random_word());
    end
    no_idle = 0;
    s_axis_tvalid <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    done = 1;
    $display("Covered %0d words over all op codes, extreme channels and scale signs;", sent);
    $display("%0d result pixels checked under random and long backpressure.", matched);
    if (fail_count == 0 && pending == 0) begin
      $display("rgba_channel_blend_alu: match");
    end else begin
      $display("rgba_channel_blend_alu: mismatch");
    end
    $finish;
  end
endmodule

@@ rgba_channel_blend_alu.f @@
+incdir+sv
sv/rcb_pkg.sv
sv/rcb_cell.sv
sv/rcb_lane.sv
sv/rgba_channel_blend_alu.sv
dv/rgba_blend_checker.sv
dv/testbench.sv
